FILE: design/d96sa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// d96sa_pkg
// Types and constants shared by the scaled decimal adder.
// ----------------------------------------------------------------------------
package d96sa_pkg;

    localparam int LOW_W   = 64;
    localparam int HIGH_W  = 32;
    localparam int MANT_W  = LOW_W + HIGH_W;
    localparam int SCALE_W = 5;
    localparam int ALU_W   = MANT_W + 4;

    localparam logic [MANT_W-1:0] SAT_MANT = {{(MANT_W-1){1'b1}}, 1'b0};

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OVF_POS = 2'd1,
        ST_OVF_NEG = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_MUL10  = 2'd0,
        OP_ADD    = 2'd1,
        OP_SUB_AB = 2'd2,
        OP_SUB_BA = 2'd3
    } alu_op_t;

    typedef struct packed {
        alu_op_t op;
        logic    sel_b;
    } alu_ctrl_t;

    typedef struct packed {
        logic ovf;
        logic neg;
        logic zero;
    } alu_flags_t;

endpackage
`default_nettype wire

FILE: design/d96sa_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// d96sa_alu
// Shared 100-bit adder: times ten, add, and subtract in either direction.
// ----------------------------------------------------------------------------
module d96sa_alu (
    input  wire d96sa_pkg::alu_ctrl_t           ctrl,
    input  wire logic [d96sa_pkg::MANT_W-1:0]   op_a,
    input  wire logic [d96sa_pkg::MANT_W-1:0]   op_b,
    output logic      [d96sa_pkg::MANT_W-1:0]   result,
    output d96sa_pkg::alu_flags_t               flags
);
    import d96sa_pkg::*;

    logic [MANT_W-1:0] m;
    logic [ALU_W-1:0]  x;
    logic [ALU_W-1:0]  y;
    logic              cin;
    logic [ALU_W-1:0]  sum;

    assign m = ctrl.sel_b ? op_b : op_a;

    always_comb begin
        unique case (ctrl.op)
            OP_MUL10: begin
                x   = {1'b0, m, 3'b000};
                y   = {3'b000, m, 1'b0};
                cin = 1'b0;
            end
            OP_ADD: begin
                x   = {4'h0, op_a};
                y   = {4'h0, op_b};
                cin = 1'b0;
            end
            OP_SUB_AB: begin
                x   = {4'h0, op_a};
                y   = {4'hF, ~op_b};
                cin = 1'b1;
            end
            OP_SUB_BA: begin
                x   = {4'h0, op_b};
                y   = {4'hF, ~op_a};
                cin = 1'b1;
            end
            default: begin
                x   = '0;
                y   = '0;
                cin = 1'b0;
            end
        endcase
    end

    assign sum        = x + y + {{(ALU_W-1){1'b0}}, cin};
    assign result     = sum[MANT_W-1:0];
    assign flags.ovf  = |sum[ALU_W-1:MANT_W];
    assign flags.neg  = sum[ALU_W-1];
    assign flags.zero = (sum[MANT_W-1:0] == '0);

endmodule
`default_nettype wire

FILE: design/decimal96_scaled_add.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// decimal96_scaled_add
// Sign-magnitude decimal add of two 96-bit mantissas with power-of-ten scales.
// ----------------------------------------------------------------------------
// Sequence: after the input transfer, S_SCALE multiplies the lower-scale operand
//   by ten |a_scale - b_scale| times (scales clamped to MAX_SCALE) unless a step
//   overflows, S_ADD adds, and S_SUBBA follows when unlike signs leave the second operand larger.
// Inputs: a new item is taken only in S_IDLE, after the last result transfers;
//   the times-ten steps go through the single shared 100-bit adder.
// Reset: synchronous, active low; clears the sequencer and m_valid.
module decimal96_scaled_add #(
    parameter int MAX_SCALE = 28
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [d96sa_pkg::LOW_W-1:0]         s_a_low,
    input  wire logic [d96sa_pkg::HIGH_W-1:0]        s_a_high,
    input  wire logic [d96sa_pkg::SCALE_W-1:0]       s_a_scale,
    input  wire logic                                s_a_neg,
    input  wire logic [d96sa_pkg::LOW_W-1:0]         s_b_low,
    input  wire logic [d96sa_pkg::HIGH_W-1:0]        s_b_high,
    input  wire logic [d96sa_pkg::SCALE_W-1:0]       s_b_scale,
    input  wire logic                                s_b_neg,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic      [d96sa_pkg::LOW_W-1:0]         m_sum_low,
    output logic      [d96sa_pkg::HIGH_W-1:0]        m_sum_high,
    output logic      [d96sa_pkg::SCALE_W-1:0]       m_sum_scale,
    output logic                                     m_sum_neg,
    output logic      [1:0]                          m_status
);
    import d96sa_pkg::*;

    localparam logic [SCALE_W-1:0] MaxScaleC = SCALE_W'(MAX_SCALE);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCALE = 5'b00010,
        S_ADD   = 5'b00100,
        S_SUBBA = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [MANT_W-1:0]   a_reg, a_next;
    logic [MANT_W-1:0]   b_reg, b_next;
    logic                na_reg, na_next;
    logic                nb_reg, nb_next;
    logic                sel_b_reg, sel_b_next;
    logic [SCALE_W-1:0]  steps_reg, steps_next;
    logic [SCALE_W-1:0]  scale_reg, scale_next;
    logic [MANT_W-1:0]   res_reg, res_next;
    logic                neg_reg, neg_next;
    status_t             status_reg, status_next;

    logic [SCALE_W-1:0]  sa;
    logic [SCALE_W-1:0]  sb;
    alu_ctrl_t           ctrl;
    logic [MANT_W-1:0]   alu_res;
    alu_flags_t          flags;

    assign sa = (s_a_scale > MaxScaleC) ? MaxScaleC : s_a_scale;
    assign sb = (s_b_scale > MaxScaleC) ? MaxScaleC : s_b_scale;

    always_comb begin
        ctrl.sel_b = sel_b_reg;
        unique case (state_reg)
            S_ADD:   ctrl.op = (na_reg == nb_reg) ? OP_ADD : OP_SUB_AB;
            S_SUBBA: ctrl.op = OP_SUB_BA;
            default: ctrl.op = OP_MUL10;
        endcase
    end

    d96sa_alu u_alu (
        .ctrl   (ctrl),
        .op_a   (a_reg),
        .op_b   (b_reg),
        .result (alu_res),
        .flags  (flags)
    );

    always_comb begin
        state_next  = state_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        na_next     = na_reg;
        nb_next     = nb_reg;
        sel_b_next  = sel_b_reg;
        steps_next  = steps_reg;
        scale_next  = scale_reg;
        res_next    = res_reg;
        neg_next    = neg_reg;
        status_next = status_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    a_next      = {s_a_high, s_a_low};
                    b_next      = {s_b_high, s_b_low};
                    na_next     = s_a_neg;
                    nb_next     = s_b_neg;
                    sel_b_next  = (sa > sb);
                    steps_next  = (sa > sb) ? (sa - sb) : (sb - sa);
                    scale_next  = (sa > sb) ? sa : sb;
                    status_next = ST_OK;
                    state_next  = (sa != sb) ? S_SCALE : S_ADD;
                end
            end
            S_SCALE: begin
                if (flags.ovf) begin
                    neg_next    = sel_b_reg ? nb_reg : na_reg;
                    res_next    = SAT_MANT;
                    status_next = (sel_b_reg ? nb_reg : na_reg) ? ST_OVF_NEG : ST_OVF_POS;
                    state_next  = S_DONE;
                end else begin
                    if (sel_b_reg) begin
                        b_next = alu_res;
                    end else begin
                        a_next = alu_res;
                    end
                    steps_next = steps_reg - SCALE_W'(1);
                    if (steps_reg == SCALE_W'(1)) begin
                        state_next = S_ADD;
                    end
                end
            end
            S_ADD: begin
                if (na_reg == nb_reg) begin
                    neg_next   = na_reg;
                    state_next = S_DONE;
                    if (flags.ovf) begin
                        res_next    = SAT_MANT;
                        status_next = na_reg ? ST_OVF_NEG : ST_OVF_POS;
                    end else begin
                        res_next = alu_res;
                    end
                end else if (flags.neg) begin
                    state_next = S_SUBBA;
                end else begin
                    state_next = S_DONE;
                    res_next   = alu_res;
                    if (flags.zero) begin
                        neg_next   = 1'b0;
                        scale_next = '0;
                    end else begin
                        neg_next = na_reg;
                    end
                end
            end
            S_SUBBA: begin
                res_next   = alu_res;
                neg_next   = nb_reg;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        a_reg      <= a_next;
        b_reg      <= b_next;
        na_reg     <= na_next;
        nb_reg     <= nb_next;
        sel_b_reg  <= sel_b_next;
        steps_reg  <= steps_next;
        scale_reg  <= scale_next;
        res_reg    <= res_next;
        neg_reg    <= neg_next;
        status_reg <= status_next;
    end

    assign s_ready     = (state_reg == S_IDLE);
    assign m_valid     = (state_reg == S_DONE);
    assign m_sum_low   = res_reg[LOW_W-1:0];
    assign m_sum_high  = res_reg[MANT_W-1:LOW_W];
    assign m_sum_scale = scale_reg;
    assign m_sum_neg   = neg_reg;
    assign m_status    = status_reg;

endmodule
`default_nettype wire

FILE: design/d96sa_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// d96sa_checker
// Port-level checks of the scaled decimal adder, bound to the top level.
// ----------------------------------------------------------------------------
module d96sa_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [63:0] m_sum_low,
    input wire logic [31:0] m_sum_high,
    input wire logic        m_sum_neg,
    input wire logic [1:0]  m_status
);
    import d96sa_pkg::*;

    // busy after an input transfer
    a_busy_after_in: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while busy");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("ready while result pending");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_OK || m_status == ST_OVF_POS
                     || m_status == ST_OVF_NEG))
        else $error("bad status code");

    a_saturation: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_OK) |->
            (m_sum_high == 32'hFFFF_FFFF) && (m_sum_low == 64'hFFFF_FFFF_FFFF_FFFE)
            && (m_sum_neg == (m_status == ST_OVF_NEG)))
        else $error("overflow result not saturated");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sum_low) && $stable(m_status))
        else $error("result changed before transfer");

endmodule

bind decimal96_scaled_add d96sa_checker u_d96sa_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_sum_low  (m_sum_low),
    .m_sum_high (m_sum_high),
    .m_sum_neg  (m_sum_neg),
    .m_status   (m_status)
);
`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for decimal96_scaled_add. Directed corner operands come
// first, then shaped random pairs that hit alignment and sum overflow edges,
// exact cancellation and clamped scales. Every result transfer is checked
// field by field against an in-bench model of the aligned sign-magnitude add.
// Both channels idle at random in the first two of three phases, not in the third.
// ----------------------------------------------------------------------------
module tb_top;
    import d96sa_pkg::*;

    localparam int MAX_SCALE   = 28;
    localparam int N_RANDOM    = 650;
    localparam int TAIL_CYCLES = 40;

    localparam logic [1:0] IDLE_SLOW_SINK   = 2'd0;
    localparam logic [1:0] IDLE_SLOW_SOURCE = 2'd1;
    localparam logic [1:0] IDLE_NONE        = 2'd2;

    localparam logic [MANT_W-1:0] MANT_MAX = {MANT_W{1'b1}};

    typedef struct packed {
        logic [LOW_W-1:0]   a_low;
        logic [HIGH_W-1:0]  a_high;
        logic [SCALE_W-1:0] a_scale;
        logic               a_neg;
        logic [LOW_W-1:0]   b_low;
        logic [HIGH_W-1:0]  b_high;
        logic [SCALE_W-1:0] b_scale;
        logic               b_neg;
        logic [1:0]         idle_mode;
        logic               drain_first;
    } add_req_t;

    typedef struct packed {
        logic [LOW_W-1:0]   sum_low;
        logic [HIGH_W-1:0]  sum_high;
        logic [SCALE_W-1:0] sum_scale;
        logic               sum_neg;
        status_t            status;
    } add_sum_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    logic [LOW_W-1:0]    s_a_low   = '0;
    logic [HIGH_W-1:0]   s_a_high  = '0;
    logic [SCALE_W-1:0]  s_a_scale = '0;
    logic                s_a_neg   = 1'b0;
    logic [LOW_W-1:0]    s_b_low   = '0;
    logic [HIGH_W-1:0]   s_b_high  = '0;
    logic [SCALE_W-1:0]  s_b_scale = '0;
    logic                s_b_neg   = 1'b0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    logic [LOW_W-1:0]    m_sum_low;
    logic [HIGH_W-1:0]   m_sum_high;
    logic [SCALE_W-1:0]  m_sum_scale;
    logic                m_sum_neg;
    logic [1:0]          m_status;

    logic [1:0]          idle_mode = IDLE_SLOW_SINK;
    add_req_t            req_pending[$];
    add_req_t            in_flight;
    add_sum_t            sum_expected[$];
    add_sum_t            exp_sum;
    int                  fail_count = 0;

    decimal96_scaled_add #(
        .MAX_SCALE(MAX_SCALE)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_a_low     (s_a_low),
        .s_a_high    (s_a_high),
        .s_a_scale   (s_a_scale),
        .s_a_neg     (s_a_neg),
        .s_b_low     (s_b_low),
        .s_b_high    (s_b_high),
        .s_b_scale   (s_b_scale),
        .s_b_neg     (s_b_neg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_sum_low   (m_sum_low),
        .m_sum_high  (m_sum_high),
        .m_sum_scale (m_sum_scale),
        .m_sum_neg   (m_sum_neg),
        .m_status    (m_status)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int idle_pct(logic [1:0] mode, bit sender);
        case (mode)
            IDLE_SLOW_SINK:   return sender ? 14 : 86;
            IDLE_SLOW_SOURCE: return sender ? 86 : 14;
            default:          return 0;
        endcase
    endfunction

    // Aligned sign-magnitude add with saturation.
    function automatic add_sum_t predict_sum(add_req_t r);
        logic [MANT_W+3:0]  ma, mb, wide;
        logic [SCALE_W-1:0] sa, sb;
        logic               ovf, neg;
        add_sum_t           s;
        ma   = {4'b0, r.a_high, r.a_low};
        mb   = {4'b0, r.b_high, r.b_low};
        sa   = (r.a_scale > MAX_SCALE) ? SCALE_W'(MAX_SCALE) : r.a_scale;
        sb   = (r.b_scale > MAX_SCALE) ? SCALE_W'(MAX_SCALE) : r.b_scale;
        ovf  = 1'b0;
        neg  = 1'b0;
        wide = '0;
        s.sum_scale = (sa > sb) ? sa : sb;
        while (sa < sb && !ovf) begin
            ma = ma * 10;
            if (ma[MANT_W+3:MANT_W] != 4'b0) begin
                ovf = 1'b1;
                neg = r.a_neg;
            end
            sa = sa + 1'b1;
        end
        while (sb < sa && !ovf) begin
            mb = mb * 10;
            if (mb[MANT_W+3:MANT_W] != 4'b0) begin
                ovf = 1'b1;
                neg = r.b_neg;
            end
            sb = sb + 1'b1;
        end
        if (!ovf) begin
            if (r.a_neg == r.b_neg) begin
                wide = ma + mb;
                neg  = r.a_neg;
                ovf  = wide[MANT_W];
            end else if (ma == mb) begin
                s.sum_scale = '0;
            end else if (ma > mb) begin
                wide = ma - mb;
                neg  = r.a_neg;
            end else begin
                wide = mb - ma;
                neg  = r.b_neg;
            end
        end
        {s.sum_high, s.sum_low} = ovf ? SAT_MANT : wide[MANT_W-1:0];
        s.sum_neg = neg;
        s.status  = !ovf ? ST_OK : (neg ? ST_OVF_NEG : ST_OVF_POS);
        return s;
    endfunction

    function automatic logic [MANT_W-1:0] rand_mant();
        logic [MANT_W-1:0] m, mask;
        int                len;
        m    = {$urandom, $urandom, $urandom};
        len  = ($urandom_range(3) == 0) ? MANT_W : $urandom_range(MANT_W);
        mask = (96'd1 << len) - 96'd1;
        return m & mask;
    endfunction

    function automatic add_req_t make_random_req(logic [1:0] mode);
        add_req_t          r;
        logic [MANT_W-1:0] ma, mb;
        logic [MANT_W+3:0] p, wide;
        int                sa, sb, d;
        logic              na, nb;
        ma = rand_mant();
        mb = rand_mant();
        na = $urandom_range(1);
        nb = $urandom_range(1);
        sa = $urandom_range(MAX_SCALE);
        sb = sa;
        case ($urandom_range(9))
            0, 1: begin
                sa = $urandom_range(31);
                sb = $urandom_range(31);
            end
            2, 3, 4: begin
                sb = sa + $urandom_range(6) - 3;
                if (sb < 0) sb = 0;
                if (sb > MAX_SCALE) sb = MAX_SCALE;
            end
            5: begin
                // cancels exactly once aligned
                d  = $urandom_range(5);
                sa = $urandom_range(MAX_SCALE - d);
                sb = sa + d;
                ma = ma & ((96'd1 << 70) - 96'd1);
                mb = ma;
                repeat (d) mb = mb * 10;
                nb = ~na;
            end
            6: begin
                mb = ma + $urandom_range(4) - 2;
                if ($urandom_range(3) != 0) nb = ~na;
            end
            7: begin
                // scaled operand right at the 96-bit limit
                d  = $urandom_range(1, MAX_SCALE);
                sa = $urandom_range(MAX_SCALE - d);
                sb = sa + d;
                p  = 1;
                repeat (d) p = p * 10;
                wide = {4'b0, MANT_MAX} / p;
                ma = wide[MANT_W-1:0] + $urandom_range(1);
                if ($urandom_range(3) == 0) ma = ma - $urandom_range(1000);
            end
            8: begin
                // like-sign sum around 2**96
                mb = ~ma + $urandom_range(2);
                nb = na;
            end
            default: begin
                ma = $urandom_range(1000);
                mb = $urandom_range(1000);
                sb = $urandom_range(MAX_SCALE);
            end
        endcase
        if ($urandom_range(1)) begin
            {r.a_high, r.a_low} = mb;
            {r.b_high, r.b_low} = ma;
            r.a_scale = sb[SCALE_W-1:0];
            r.b_scale = sa[SCALE_W-1:0];
            r.a_neg   = nb;
            r.b_neg   = na;
        end else begin
            {r.a_high, r.a_low} = ma;
            {r.b_high, r.b_low} = mb;
            r.a_scale = sa[SCALE_W-1:0];
            r.b_scale = sb[SCALE_W-1:0];
            r.a_neg   = na;
            r.b_neg   = nb;
        end
        r.idle_mode   = mode;
        r.drain_first = 1'b0;
        return r;
    endfunction

    task automatic add_directed(logic [MANT_W-1:0] ma, int sa, logic na,
                                logic [MANT_W-1:0] mb, int sb, logic nb);
        add_req_t r;
        {r.a_high, r.a_low} = ma;
        {r.b_high, r.b_low} = mb;
        r.a_scale     = sa[SCALE_W-1:0];
        r.b_scale     = sb[SCALE_W-1:0];
        r.a_neg       = na;
        r.b_neg       = nb;
        r.idle_mode   = IDLE_SLOW_SINK;
        r.drain_first = 1'b0;
        req_pending.push_back(r);
    endtask

    // source side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                sum_expected.push_back(predict_sum(in_flight));
            end
            if (!s_valid || s_ready) begin
                if (req_pending.size() != 0 &&
                    !(req_pending[0].drain_first && sum_expected.size() != 0) &&
                    $urandom_range(99) >= idle_pct(req_pending[0].idle_mode, 1'b1)) begin
                    in_flight = req_pending.pop_front();
                    s_a_low   <= in_flight.a_low;
                    s_a_high  <= in_flight.a_high;
                    s_a_scale <= in_flight.a_scale;
                    s_a_neg   <= in_flight.a_neg;
                    s_b_low   <= in_flight.b_low;
                    s_b_high  <= in_flight.b_high;
                    s_b_scale <= in_flight.b_scale;
                    s_b_neg   <= in_flight.b_neg;
                    idle_mode <= in_flight.idle_mode;
                    s_valid   <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (sum_expected.size() == 0) begin
                    $error("result transfer with no sum expected");
                    fail_count++;
                end else begin
                    exp_sum = sum_expected.pop_front();
                    if (m_sum_low !== exp_sum.sum_low) begin
                        $error("sum_low: expected %h, got %h", exp_sum.sum_low, m_sum_low);
                        fail_count++;
                    end
                    if (m_sum_high !== exp_sum.sum_high) begin
                        $error("sum_high: expected %h, got %h", exp_sum.sum_high, m_sum_high);
                        fail_count++;
                    end
                    if (m_sum_scale !== exp_sum.sum_scale) begin
                        $error("sum_scale: expected %0d, got %0d",
                               exp_sum.sum_scale, m_sum_scale);
                        fail_count++;
                    end
                    if (m_sum_neg !== exp_sum.sum_neg) begin
                        $error("sum_neg: expected %0d, got %0d", exp_sum.sum_neg, m_sum_neg);
                        fail_count++;
                    end
                    if (m_status !== exp_sum.status) begin
                        $error("status: expected %0d, got %0d", exp_sum.status, m_status);
                        fail_count++;
                    end
                end
            end
            m_ready <= $urandom_range(99) >= idle_pct(idle_mode, 1'b0);
        end
    end

    initial begin
        add_req_t r;
        int       i;
        add_directed('0, 0, 1'b0, '0, 0, 1'b0);
        add_directed('0, 3, 1'b0, '0, 7, 1'b1);
        add_directed('0, 5, 1'b1, '0, 5, 1'b1);
        add_directed(MANT_MAX, 0, 1'b0, 96'd1, 0, 1'b0);
        add_directed(MANT_MAX, 12, 1'b1, MANT_MAX, 12, 1'b1);
        add_directed(MANT_MAX, 9, 1'b0, MANT_MAX, 9, 1'b1);
        add_directed(96'd1, 0, 1'b1, 96'd1, 28, 1'b0);
        add_directed(96'd8, 0, 1'b1, 96'd5, 28, 1'b0);
        add_directed(96'd5, 28, 1'b1, MANT_MAX, 0, 1'b0);
        add_directed(96'd123, 31, 1'b0, 96'd7, 0, 1'b0);
        add_directed(96'd1000, 29, 1'b0, 96'd1, 30, 1'b1);
        add_directed(96'd5, 4, 1'b0, 96'd9, 4, 1'b1);
        add_directed(96'h1_0000_0000_0000_0000, 2, 1'b1, 96'd1, 2, 1'b0);
        add_directed(96'hFFFF_FFFF_FFFF_FFFF, 6, 1'b0, 96'd1, 6, 1'b0);
        add_directed(96'd1, 1, 1'b0, 96'd10, 2, 1'b1);
        add_directed(96'd3, 0, 1'b1, 96'd29, 1, 1'b0);
        add_directed(MANT_MAX, 20, 1'b0, '0, 20, 1'b1);
        add_directed(SAT_MANT, 0, 1'b0, 96'd1, 0, 1'b0);
        add_directed(96'h8000_0000_0000_0000_0000_0000, 0, 1'b0,
                     96'h8000_0000_0000_0000_0000_0000, 0, 1'b0);
        add_directed({$urandom, $urandom, $urandom}, 31, 1'b0,
                     {$urandom, $urandom, $urandom}, 31, 1'b1);
        add_directed(96'h1999_9999_9999_9999_9999_9999, 0, 1'b0, '0, 1, 1'b0);
        add_directed(96'h1999_9999_9999_9999_9999_999A, 0, 1'b1, '0, 1, 1'b0);
        for (i = 0; i < N_RANDOM; i++) begin
            r = make_random_req(i < N_RANDOM / 3 ? IDLE_SLOW_SINK :
                                i < 2 * N_RANDOM / 3 ? IDLE_SLOW_SOURCE : IDLE_NONE);
            r.drain_first = (i == N_RANDOM / 3) || (i == 2 * N_RANDOM / 3);
            req_pending.push_back(r);
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        while (req_pending.size() != 0 || s_valid || sum_expected.size() != 0)
            @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (fail_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
